[rtl/pfba_pkg.sv]
package pfba_pkg;
    localparam int MAX_FRAMES = 65536;
    localparam int WORD_BITS  = 32;
    localparam int MAX_RUN    = 256;
    localparam int ACTION_W   = 3;
    localparam int FRAME_W    = 16;
    localparam int RUN_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 17;
    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 17'd65536;

    localparam logic [ACTION_W-1:0] ACT_RESERVE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TEST    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ALLOC1  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ALLOCN  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
endpackage

[rtl/pfba_if.sv]
interface pfba_req_if;
    logic                           valid;
    logic                           ready;
    logic [pfba_pkg::ACTION_W-1:0]  action;
    logic [pfba_pkg::FRAME_W-1:0]   frame_index;
    logic [pfba_pkg::RUN_W-1:0]     run_length;
    modport source (output valid, action, frame_index, run_length, input ready);
    modport sink   (input valid, action, frame_index, run_length, output ready);
endinterface

interface pfba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pfba_pkg::STATUS_W-1:0]  status;
    logic [pfba_pkg::FRAME_W-1:0]   result_frame;
    logic                           is_used;
    logic [pfba_pkg::COUNT_W-1:0]   used_frames;
    modport source (output valid, status, result_frame, is_used, used_frames, input ready);
    modport sink   (input valid, status, result_frame, is_used, used_frames, output ready);
endinterface

[rtl/page_frame_bitmap_allocator.sv]
// channel   | dir | fields
// ----------+-----+-------------------------------------------
// i_req     | in  | action, frame_index, run_length
// o_rsp     | out | status, result_frame, is_used, used_frames
// i_cfg_*   | in  | frame_count (write only)
// reset: clearing pass over all words of the bitmap, one word a cycle
// reserve, free, test: read, wait, check, then a write for a reserve of a free frame
// allocate: scans a frame a cycle in a word, read and wait per new word, then marks frames
// out-of-range, unknown action and bad run length answer the cycle after the request
// a finished response waits in an output register; a new request is taken once it is taken
module page_frame_bitmap_allocator #(
    parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES,
    parameter int WORD_BITS  = pfba_pkg::WORD_BITS,
    parameter int MAX_RUN    = pfba_pkg::MAX_RUN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pfba_pkg::COUNT_W-1:0] i_cfg_wdata,
    pfba_req_if.sink                     i_req,
    pfba_rsp_if.source                   o_rsp
);
    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int FW    = $clog2(MAX_FRAMES + 1) + 1;
    localparam int LW    = $clog2(MAX_RUN + 1) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_WAIT, S_CHK, S_MARK_RD, S_MARK_WAIT,
        S_MARK_WR, S_RESP
    } t_state;

    t_state r_state;
    logic [pfba_pkg::COUNT_W-1:0]  r_fcount, r_used;
    logic [pfba_pkg::ACTION_W-1:0] r_act;
    logic [FW-1:0]                 r_f;       // scan or target frame
    logic [FW-1:0]                 r_start;
    logic [LW-1:0]                 r_run, r_left;
    logic [LW-1:0]                 r_len;
    logic [AW-1:0]                 r_clr;
    logic [pfba_pkg::STATUS_W-1:0] r_status;
    logic [pfba_pkg::FRAME_W-1:0]  r_result;
    logic                          r_isused;
    logic [FW-1:0]                 w_limit;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_rdata;
    logic [BW-1:0]        w_bit;
    logic                 w_b;

    pfba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // active frame count, clipped to the bitmap size
    assign w_limit = ({{(FW-pfba_pkg::COUNT_W){1'b0}}, r_fcount} > FW'(MAX_FRAMES))
                   ? FW'(MAX_FRAMES) : {{(FW-pfba_pkg::COUNT_W){1'b0}}, r_fcount};

    assign w_raddr = AW'(r_f / WORD_BITS);
    assign w_bit   = BW'(r_f % WORD_BITS);
    assign w_b     = w_rdata[w_bit];

    // memory write: clearing pass, single-bit update
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_raddr;
        w_wdata = w_rdata;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_MARK_WR) begin
            w_we = 1'b1;
            w_wdata[w_bit] = 1'b1;
        end else if (r_state == S_CHK && r_act == pfba_pkg::ACT_FREE) begin
            w_we = w_b;
            w_wdata[w_bit] = 1'b0;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = (r_state == S_RESP);
    assign o_rsp.status       = r_status;
    assign o_rsp.result_frame = r_result;
    assign o_rsp.is_used      = r_isused;
    assign o_rsp.used_frames  = r_used;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_used   <= '0;
            r_fcount <= pfba_pkg::FRAME_COUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_fcount <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_act    <= i_req.action;
                        r_len    <= LW'(i_req.run_length);
                        r_run    <= '0;
                        r_status <= pfba_pkg::ST_DONE;
                        r_result <= '0;
                        r_isused <= 1'b0;
                        r_state  <= S_RD;
                        if (i_req.action == pfba_pkg::ACT_ALLOC1 ||
                            i_req.action == pfba_pkg::ACT_ALLOCN) begin
                            r_f <= '0;
                            if (w_limit == '0 || (i_req.action == pfba_pkg::ACT_ALLOCN &&
                                (i_req.run_length == '0 ||
                                 LW'(i_req.run_length) > LW'(MAX_RUN)))) begin
                                r_status <= pfba_pkg::ST_NONE;
                                r_state  <= S_RESP;
                            end
                        end else begin
                            r_f <= FW'(i_req.frame_index);
                            if (i_req.action > pfba_pkg::ACT_ALLOCN ||
                                FW'(i_req.frame_index) >= w_limit) begin
                                r_status <= pfba_pkg::ST_RANGE;
                                r_state  <= S_RESP;
                            end
                        end
                    end
                end
                S_RD:   r_state <= S_WAIT;
                S_WAIT: r_state <= S_CHK;
                S_CHK: begin
                    case (r_act)
                        pfba_pkg::ACT_RESERVE: begin
                            if (!w_b) begin
                                r_used  <= r_used + 1'b1;
                                r_state <= S_MARK_WR;
                            end else begin
                                r_state <= S_RESP;
                            end
                        end
                        pfba_pkg::ACT_FREE: begin
                            if (w_b) begin
                                r_used <= r_used - 1'b1;
                            end
                            r_state <= S_RESP;
                        end
                        pfba_pkg::ACT_TEST: begin
                            r_isused <= w_b;
                            r_state  <= S_RESP;
                        end
                        pfba_pkg::ACT_ALLOC1: begin
                            if (!w_b) begin
                                r_used   <= r_used + 1'b1;
                                r_result <= pfba_pkg::FRAME_W'(r_f);
                                r_state  <= S_MARK_WR;
                            end else if (r_f + FW'(1) >= w_limit) begin
                                r_status <= pfba_pkg::ST_NONE;
                                r_state  <= S_RESP;
                            end else begin
                                r_f <= r_f + FW'(1);
                                // same word: data stays valid, next bit
                                r_state <= (w_bit == BW'(WORD_BITS - 1)) ? S_RD : S_CHK;
                            end
                        end
                        default: begin
                            if (!w_b && r_run + LW'(1) == r_len) begin
                                r_start <= (r_run == '0) ? r_f : r_start;
                                r_result <= pfba_pkg::FRAME_W'((r_run == '0) ? r_f : r_start);
                                r_f     <= (r_run == '0) ? r_f : r_start;
                                r_left  <= r_len;
                                r_used  <= r_used + pfba_pkg::COUNT_W'(r_len);
                                r_state <= S_MARK_RD;
                            end else if (r_f + FW'(1) >= w_limit) begin
                                r_status <= pfba_pkg::ST_NONE;
                                r_state  <= S_RESP;
                            end else begin
                                if (w_b) begin
                                    r_run <= '0;
                                end else begin
                                    if (r_run == '0) r_start <= r_f;
                                    r_run <= r_run + LW'(1);
                                end
                                r_f <= r_f + FW'(1);
                                r_state <= (w_bit == BW'(WORD_BITS - 1)) ? S_RD : S_CHK;
                            end
                        end
                    endcase
                end
                S_MARK_RD:   r_state <= S_MARK_WAIT;
                S_MARK_WAIT: r_state <= S_MARK_WR;
                S_MARK_WR: begin
                    if (r_act == pfba_pkg::ACT_ALLOCN && r_left > LW'(1)) begin
                        r_left  <= r_left - LW'(1);
                        r_f     <= r_f + FW'(1);
                        r_state <= S_MARK_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/pfba_ram.sv]
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/pfba_checker.sv]
module pfba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [pfba_pkg::STATUS_W-1:0] i_status,
    input logic [pfba_pkg::FRAME_W-1:0]  i_result_frame,
    input logic                         i_is_used
);
    // no new request while a response is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready) else $error("request taken with response pending");
    // one request at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second request taken back to back");
    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status)))
        else $error("response changed while stalled");
    // failures give frame zero
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status != pfba_pkg::ST_DONE) |-> (i_result_frame == '0 && !i_is_used))
        else $error("failure carries data");
    // status codes are in range
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status <= pfba_pkg::ST_NONE)) else $error("bad status");
endmodule

bind page_frame_bitmap_allocator pfba_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
    .i_status(o_rsp.status), .i_result_frame(o_rsp.result_frame),
    .i_is_used(o_rsp.is_used)
);
